// ===== rtl/core/ipd_pkg.sv =====
package ipd_pkg;

    localparam int PAYLOAD_LEN = 40;
    localparam int OUT_BITS    = PAYLOAD_LEN * 8;
    localparam int COUNT_W     = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int PADDR_W     = 3;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'h55;

    localparam logic [COUNT_W-1:0] LAST_PAYLOAD = COUNT_W'(PAYLOAD_LEN - 1);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_PAYLOAD,
        KIND_CHECK
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

endpackage

// ===== rtl/core/imu_packet_deframer.sv =====
// imu packet deframer
// s_ channel: one received serial byte per word in s_tdata[7:0]
// m_ channel: one word per good packet, ten 32-bit float bit patterns
//   in m_tdata, quat_w in the lowest bits up to accel_z in the highest
// apb port: header_first at 0x0, header_second at 0x4, pready always high
// the front hunts for the two-byte header and counts 40 payload bytes,
//   pushing tagged bytes into a 4-entry queue; the back folds the xor,
//   shifts the payload into a 320-bit register and checks the checksum
// throughput: one byte per cycle while the queue has room
// result path: the checksum byte is written into the queue, then the back
//   loads the output register, later while the queue still holds earlier
//   bytes
// reset: hunt restarts, queue and output empty, headers 0xAA and 0x55
// receiver stall: a result holds in the output register while the next
//   packet keeps streaming into the shift register; the back waits only
//   at a checksum byte, and s_tready drops once the queue fills
module imu_packet_deframer
    import ipd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z,
    // accel_x, accel_y, accel_z
    output logic [OUT_BITS-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0] header_first_reg, header_second_reg;
    logic       cfg_write;
    logic       byte_valid;
    logic       q_full, q_push, q_pop, q_valid;
    entry_t     q_push_entry, q_pop_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_HEADER_FIRST:  header_first_reg  <= pwdata[7:0];
                REG_HEADER_SECOND: header_second_reg <= pwdata[7:0];
                default:           header_first_reg  <= header_first_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HEADER_FIRST:  prdata = {24'd0, header_first_reg};
            REG_HEADER_SECOND: prdata = {24'd0, header_second_reg};
            default:           prdata = '0;
        endcase
    end

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    ipd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .byte_valid    (byte_valid),
        .byte_data     (s_tdata),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    ipd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_entry  (q_pop_entry),
        .pop        (q_pop)
    );

    ipd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_valid (q_valid),
        .entry       (q_pop_entry),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== rtl/core/ipd_front.sv =====
module ipd_front
    import ipd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] header_first,
    input  logic [7:0] header_second,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       push,
    output entry_t     push_entry
);

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        push            = 1'b0;
        push_entry.kind = KIND_PAYLOAD;
        push_entry.data = byte_data;
        if (byte_valid) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    if (byte_data == header_first) begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (byte_data == header_second) begin
                        phase_next      = PH_PAYLOAD;
                        count_next      = '0;
                        push            = 1'b1;
                        push_entry.kind = KIND_START;
                        push_entry.data = header_first ^ header_second;
                    end else if (byte_data != header_first) begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_PAYLOAD: begin
                    push       = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    if (count_reg == LAST_PAYLOAD) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    push            = 1'b1;
                    push_entry.kind = KIND_CHECK;
                    phase_next      = PH_FIRST;
                    count_next      = '0;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ipd_fifo.sv =====
module ipd_fifo
    import ipd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   pop_valid,
    output entry_t pop_entry,
    input  logic   pop
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    logic do_push, do_pop;

    assign full      = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/ipd_back.sv =====
module ipd_back
    import ipd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                entry_valid,
    input  entry_t              entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata
);

    logic [OUT_BITS-1:0] shift_reg;
    logic [OUT_BITS-1:0] out_reg;
    logic [7:0]          xor_reg;
    logic                out_valid_reg;
    logic                slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign pop       = entry_valid && ((entry.kind != KIND_CHECK) || slot_free);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (pop && entry.kind == KIND_CHECK && entry.data == xor_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload shifts in at the top so byte 0 ends in the lowest bits
    always_ff @(posedge aclk) begin
        if (pop) begin
            unique case (entry.kind)
                KIND_START: begin
                    xor_reg <= entry.data;
                end
                KIND_PAYLOAD: begin
                    xor_reg   <= xor_reg ^ entry.data;
                    shift_reg <= {entry.data, shift_reg[OUT_BITS-1:8]};
                end
                KIND_CHECK: begin
                    if (entry.data == xor_reg) begin
                        out_reg <= shift_reg;
                    end
                end
                default: begin
                    xor_reg <= xor_reg;
                end
            endcase
        end
    end

endmodule
